// File: sv/pkit_pkg.sv
// Shared types and constants for the peer key interning table.
// Used by pkit_store and the top level peer_key_id_interning_table; no dependencies.
package pkit_pkg;

    localparam int ENTRIES  = 256;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int ID_W     = 16;
    localparam int TOTAL_W  = 9;
    localparam int IN_W     = 312;
    localparam int OUT_W    = 320;

    localparam logic [ID_W-1:0] ID_FIRST = 16'd1;
    // The last ID value is never handed out.
    localparam logic [ID_W-1:0] ID_LIMIT = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_GET_ID   = 2'd0,
        OP_GET_SIG  = 2'd1,
        OP_GET_SIZE = 2'd2,
        OP_CLEAR    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STATUS_FOUND     = 2'd0,
        STATUS_INSERTED  = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_PUSH
    } state_t;

    typedef struct packed {
        op_t              operation;
        logic             addr_version;
        logic [63:0]      addr_hi;
        logic [63:0]      addr_lo;
        logic [63:0]      collector_hi;
        logic [63:0]      collector_lo;
        logic [31:0]      asn;
        logic [ID_W-1:0]  query_id;
    } req_t;

    typedef struct packed {
        logic             version;
        logic [63:0]      addr_hi;
        logic [63:0]      addr_lo;
        logic [63:0]      coll_hi;
        logic [63:0]      coll_lo;
        logic [31:0]      asn;
        logic [ID_W-1:0]  id;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } wr_req_t;

    typedef struct packed {
        status_t            status;
        logic [ID_W-1:0]    peer_id;
        logic               version;
        logic [63:0]        addr_hi;
        logic [63:0]        addr_lo;
        logic [63:0]        coll_hi;
        logic [63:0]        coll_lo;
        logic [31:0]        asn;
        logic [TOTAL_W-1:0] total;
    } result_t;

endpackage

// File: sv/pkit_store.sv
// Entry storage for the peer key interning table: one synchronous entry memory
// with a registered read port, plus a valid bit per slot. Depends on pkit_pkg.
module pkit_store (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [pkit_pkg::IDX_W-1:0] rd_addr,
    input  pkit_pkg::wr_req_t        wr,
    input  logic                     clr,
    output pkit_pkg::entry_t         rd_data,
    output logic                     rd_valid
);
    import pkit_pkg::*;

    entry_t             mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    entry_t             rd_data_reg;
    logic               rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr)
            begin
                valid_reg <= '0;
            end
            else if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

// File: sv/peer_key_id_interning_table.sv
// Top level of the peer key interning table: request sequencer and output register.
// Depends on pkit_pkg and pkit_store.
//
// The table hands out small IDs (from 1) to peer keys made of address version,
// 128-bit address and 16-byte collector name, and keeps up to 256 entries in one
// single-port-read memory. get_id and get_sig walk the memory one slot per cycle,
// stopping early when the entry is found; get_size and clear skip the walk.
// One word is processed at a time; a finished
// result sits in the output register while the next word is taken. After reset the
// table is empty and ready at once. clear empties the table but IDs keep counting;
// once the ID counter reaches 65535, or all slots are used, new keys get table_full.
module peer_key_id_interning_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // operation[1:0], addr_version[2], addr_hi[66:3], addr_lo[130:67],
    // collector_hi[194:131], collector_lo[258:195], asn[290:259], query_id[306:291]
    input  logic [pkit_pkg::IN_W-1:0]   s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // status[1:0], peer_id[17:2], out_version[18], out_addr_hi[82:19],
    // out_addr_lo[146:83], out_collector_hi[210:147], out_collector_lo[274:211],
    // out_asn[306:275], entry_total[315:307]
    output logic [pkit_pkg::OUT_W-1:0]  m_tdata
);
    import pkit_pkg::*;

    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(ENTRIES);

    state_t             state_reg, state_next;
    req_t               req_reg, req_next;
    logic [IDX_W-1:0]   issue_reg, issue_next;
    logic               issue_done_reg, issue_done_next;
    logic               chk_reg;
    logic [IDX_W-1:0]   chk_slot_reg;
    logic               free_seen_reg, free_seen_next;
    logic [IDX_W-1:0]   free_slot_reg, free_slot_next;
    logic [ID_W-1:0]    next_id_reg, next_id_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    result_t            res_reg, res_next;
    result_t            out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    req_t               in_req;
    logic               rd_en;
    entry_t             rd_data;
    logic               rd_valid;
    wr_req_t            wr;
    logic               clr;
    logic               key_eq;
    logic               id_eq;
    logic               hit;
    logic [IDX_W-1:0]   ins_slot;

    assign in_req.operation    = op_t'(s_tdata[1:0]);
    assign in_req.addr_version = s_tdata[2];
    assign in_req.addr_hi      = s_tdata[66:3];
    assign in_req.addr_lo      = s_tdata[130:67];
    assign in_req.collector_hi = s_tdata[194:131];
    assign in_req.collector_lo = s_tdata[258:195];
    assign in_req.asn          = s_tdata[290:259];
    assign in_req.query_id     = s_tdata[306:291];

    pkit_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (issue_reg),
        .wr       (wr),
        .clr      (clr),
        .rd_data  (rd_data),
        .rd_valid (rd_valid)
    );

    assign key_eq = (rd_data.version == req_reg.addr_version) &&
                    (rd_data.addr_hi == req_reg.addr_hi) &&
                    (rd_data.addr_lo == req_reg.addr_lo) &&
                    (rd_data.coll_hi == req_reg.collector_hi) &&
                    (rd_data.coll_lo == req_reg.collector_lo);
    assign id_eq  = (rd_data.id == req_reg.query_id);
    assign hit    = chk_reg && rd_valid &&
                    ((req_reg.operation == OP_GET_ID) ? key_eq : id_eq);

    // The slot being checked in the final cycle may be the first free one.
    assign ins_slot = free_seen_reg ? free_slot_reg : chk_slot_reg;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        issue_next      = issue_reg;
        issue_done_next = issue_done_reg;
        free_seen_next  = free_seen_reg;
        free_slot_next  = free_slot_reg;
        next_id_next    = next_id_reg;
        count_next      = count_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        rd_en           = 1'b0;
        wr              = '0;
        clr             = 1'b0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    req_next        = in_req;
                    issue_next      = '0;
                    issue_done_next = 1'b0;
                    free_seen_next  = 1'b0;
                    res_next        = '0;
                    unique case (in_req.operation)
                        OP_GET_ID, OP_GET_SIG:
                        begin
                            state_next = S_SCAN;
                        end
                        OP_GET_SIZE:
                        begin
                            res_next.status = STATUS_FOUND;
                            res_next.total  = TOTAL_W'(count_reg);
                            state_next      = S_PUSH;
                        end
                        OP_CLEAR:
                        begin
                            clr             = 1'b1;
                            count_next      = '0;
                            res_next.status = STATUS_FOUND;
                            state_next      = S_PUSH;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                rd_en = !issue_done_reg;
                if (rd_en)
                begin
                    issue_next = issue_reg + IDX_W'(1);
                    if (issue_reg == LAST_SLOT)
                    begin
                        issue_done_next = 1'b1;
                    end
                end

                if (chk_reg)
                begin
                    if (!rd_valid && !free_seen_reg)
                    begin
                        free_seen_next = 1'b1;
                        free_slot_next = chk_slot_reg;
                    end

                    res_next       = '0;
                    res_next.total = TOTAL_W'(count_reg);
                    if (hit)
                    begin
                        res_next.status  = STATUS_FOUND;
                        res_next.peer_id = (req_reg.operation == OP_GET_ID) ?
                                           rd_data.id : req_reg.query_id;
                        res_next.version = rd_data.version;
                        res_next.addr_hi = rd_data.addr_hi;
                        res_next.addr_lo = rd_data.addr_lo;
                        res_next.coll_hi = rd_data.coll_hi;
                        res_next.coll_lo = rd_data.coll_lo;
                        res_next.asn     = rd_data.asn;
                        state_next       = S_PUSH;
                    end
                    else if (chk_slot_reg == LAST_SLOT)
                    begin
                        state_next = S_PUSH;
                        if (req_reg.operation == OP_GET_SIG)
                        begin
                            res_next.status  = STATUS_NOT_FOUND;
                            res_next.peer_id = req_reg.query_id;
                        end
                        else if (count_reg == FULL_CNT || next_id_reg >= ID_LIMIT)
                        begin
                            res_next.status = STATUS_FULL;
                        end
                        else
                        begin
                            wr.en           = 1'b1;
                            wr.addr         = ins_slot;
                            wr.data.version = req_reg.addr_version;
                            wr.data.addr_hi = req_reg.addr_hi;
                            wr.data.addr_lo = req_reg.addr_lo;
                            wr.data.coll_hi = req_reg.collector_hi;
                            wr.data.coll_lo = req_reg.collector_lo;
                            wr.data.asn     = req_reg.asn;
                            wr.data.id      = next_id_reg;
                            next_id_next    = next_id_reg + ID_W'(1);
                            count_next      = count_reg + CNT_W'(1);
                            res_next.status  = STATUS_INSERTED;
                            res_next.peer_id = next_id_reg;
                            res_next.version = req_reg.addr_version;
                            res_next.addr_hi = req_reg.addr_hi;
                            res_next.addr_lo = req_reg.addr_lo;
                            res_next.coll_hi = req_reg.collector_hi;
                            res_next.coll_lo = req_reg.collector_lo;
                            res_next.asn     = req_reg.asn;
                            res_next.total   = TOTAL_W'(count_reg + CNT_W'(1));
                        end
                    end
                end
            end

            S_PUSH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            issue_done_reg <= 1'b0;
            chk_reg        <= 1'b0;
            free_seen_reg  <= 1'b0;
            next_id_reg    <= ID_FIRST;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_done_reg <= issue_done_next;
            chk_reg        <= rd_en;
            free_seen_reg  <= free_seen_next;
            next_id_reg    <= next_id_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        issue_reg     <= issue_next;
        chk_slot_reg  <= issue_reg;
        free_slot_reg <= free_slot_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reg.total, out_reg.asn, out_reg.coll_lo, out_reg.coll_hi,
                       out_reg.addr_lo, out_reg.addr_hi, out_reg.version, out_reg.peer_id,
                       out_reg.status};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count exceeds table size");

    a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        next_id_reg != '0)
        else $error("ID counter wrapped to zero");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && in_req.operation == OP_CLEAR) |=> (count_reg == '0))
        else $error("clear did not empty the table");

    a_insert_bumps_id: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == $past(count_reg) + CNT_W'(1)) |->
        (next_id_reg == $past(next_id_reg) + ID_W'(1)))
        else $error("entry added without a new ID");

    a_out_from_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_PUSH))
        else $error("result word loaded outside the push state");

endmodule

// File: tb/pkit_checker.sv
// Checker for the peer key interning table: watches both stream channels,
// keeps its own copy of the table and compares every result word field by field.
// Depends on pkit_pkg for the operation and status codes and the entry layout.
module pkit_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    // operation[1:0], addr_version[2], addr_hi[66:3], addr_lo[130:67],
    // collector_hi[194:131], collector_lo[258:195], asn[290:259], query_id[306:291]
    input  logic [pkit_pkg::IN_W-1:0]  s_tdata,
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    // status[1:0], peer_id[17:2], out_version[18], out_addr_hi[82:19],
    // out_addr_lo[146:83], out_collector_hi[210:147], out_collector_lo[274:211],
    // out_asn[306:275], entry_total[315:307]
    input  logic [pkit_pkg::OUT_W-1:0] m_tdata,
    output int                         errors,
    output int                         pending,
    output int                         n_inserted,
    output int                         n_found,
    output int                         n_absent,
    output int                         n_full
);
    timeunit 1ns;
    timeprecision 1ps;

    import pkit_pkg::*;

    logic            slot_used [ENTRIES];
    entry_t          slot_data [ENTRIES];
    logic [ID_W-1:0] next_id;
    int              live_count;

    result_t         predicted_results [$];
    int              err_cnt;
    int              results_seen;
    int              tally [4];

    function automatic result_t with_entry(input result_t r, input entry_t e);
        result_t o;
        o         = r;
        o.version = e.version;
        o.addr_hi = e.addr_hi;
        o.addr_lo = e.addr_lo;
        o.coll_hi = e.coll_hi;
        o.coll_lo = e.coll_lo;
        o.asn     = e.asn;
        return o;
    endfunction

    // Applies one request word to the local table and returns the result it causes.
    function automatic result_t table_apply(input logic [IN_W-1:0] w);
        op_t             op;
        logic            ver;
        logic [63:0]     ahi;
        logic [63:0]     alo;
        logic [63:0]     chi;
        logic [63:0]     clo;
        logic [31:0]     asn;
        logic [ID_W-1:0] qid;
        result_t         r;
        bit              hit;
        int              free_slot;
        entry_t          e;
        op  = op_t'(w[1:0]);
        ver = w[2];
        ahi = w[66:3];
        alo = w[130:67];
        chi = w[194:131];
        clo = w[258:195];
        asn = w[290:259];
        qid = w[306:291];
        r   = '0;
        hit = 1'b0;
        free_slot = -1;
        case (op)
            OP_GET_ID:
            begin
                for (int s = 0; s < ENTRIES; s++)
                begin
                    if (slot_used[s])
                    begin
                        if (!hit && slot_data[s].version == ver &&
                            slot_data[s].addr_hi == ahi && slot_data[s].addr_lo == alo &&
                            slot_data[s].coll_hi == chi && slot_data[s].coll_lo == clo)
                        begin
                            hit       = 1'b1;
                            r.status  = STATUS_FOUND;
                            r.peer_id = slot_data[s].id;
                            r         = with_entry(r, slot_data[s]);
                        end
                    end
                    else if (free_slot < 0)
                    begin
                        free_slot = s;
                    end
                end
                if (!hit)
                begin
                    if (free_slot < 0 || next_id >= ID_LIMIT)
                    begin
                        r.status = STATUS_FULL;
                    end
                    else
                    begin
                        e.version = ver;
                        e.addr_hi = ahi;
                        e.addr_lo = alo;
                        e.coll_hi = chi;
                        e.coll_lo = clo;
                        e.asn     = asn;
                        e.id      = next_id;
                        slot_data[free_slot] = e;
                        slot_used[free_slot] = 1'b1;
                        next_id    = next_id + ID_W'(1);
                        live_count = live_count + 1;
                        r.status   = STATUS_INSERTED;
                        r.peer_id  = e.id;
                        r          = with_entry(r, e);
                    end
                end
            end
            OP_GET_SIG:
            begin
                r.status  = STATUS_NOT_FOUND;
                r.peer_id = qid;
                for (int s = 0; s < ENTRIES; s++)
                begin
                    if (!hit && slot_used[s] && slot_data[s].id == qid)
                    begin
                        hit      = 1'b1;
                        r.status = STATUS_FOUND;
                        r        = with_entry(r, slot_data[s]);
                    end
                end
            end
            OP_CLEAR:
            begin
                for (int s = 0; s < ENTRIES; s++)
                    slot_used[s] = 1'b0;
                live_count = 0;
            end
            default:
            begin
            end
        endcase
        r.total = live_count[TOTAL_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            if (err_cnt < 10)
                $display("result word %0d: %s expected %h, got %h",
                         results_seen, name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < ENTRIES; s++)
                slot_used[s] = 1'b0;
            next_id      = ID_FIRST;
            live_count   = 0;
            err_cnt      = 0;
            results_seen = 0;
            for (int k = 0; k < 4; k++)
                tally[k] = 0;
            predicted_results.delete();
            errors     <= 0;
            pending    <= 0;
            n_found    <= 0;
            n_inserted <= 0;
            n_absent   <= 0;
            n_full     <= 0;
        end
        else
        begin
            // The result leaving now always belongs to an older request word,
            // so it is checked before this edge's request is predicted.
            if (m_tvalid && m_tready)
            begin
                if (predicted_results.size() == 0)
                begin
                    if (err_cnt < 10)
                        $display("result word %0d arrived with nothing outstanding: %h",
                                 results_seen, m_tdata);
                    err_cnt++;
                end
                else
                begin
                    result_t want;
                    want = predicted_results.pop_front();
                    check_field("status", 64'(want.status), 64'(m_tdata[1:0]));
                    check_field("peer_id", 64'(want.peer_id), 64'(m_tdata[17:2]));
                    check_field("out_version", 64'(want.version), 64'(m_tdata[18]));
                    check_field("out_addr_hi", want.addr_hi, m_tdata[82:19]);
                    check_field("out_addr_lo", want.addr_lo, m_tdata[146:83]);
                    check_field("out_collector_hi", want.coll_hi, m_tdata[210:147]);
                    check_field("out_collector_lo", want.coll_lo, m_tdata[274:211]);
                    check_field("out_asn", 64'(want.asn), 64'(m_tdata[306:275]));
                    check_field("entry_total", 64'(want.total), 64'(m_tdata[315:307]));
                    tally[want.status]++;
                end
                results_seen++;
            end
            if (s_tvalid && s_tready)
                predicted_results.push_back(table_apply(s_tdata));
            errors     <= err_cnt;
            pending    <= predicted_results.size();
            n_found    <= tally[STATUS_FOUND];
            n_inserted <= tally[STATUS_INSERTED];
            n_absent   <= tally[STATUS_NOT_FOUND];
            n_full     <= tally[STATUS_FULL];
        end
    end

endmodule

// File: tb/tb_peer_key_id_interning_table.sv
// Testbench top for the peer key interning table: clock, reset, request words
// and output back-pressure; the verdict comes from the error and pending counts of pkit_checker.
// Depends on pkit_pkg, pkit_checker and the block peer_key_id_interning_table.
module tb_peer_key_id_interning_table;
    timeunit 1ns;
    timeprecision 1ps;

    import pkit_pkg::*;

    localparam int REQ_BITS    = 307;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int TAIL_CYCLES = 300;
    localparam int POOL_DEPTH  = 48;

    typedef struct packed {
        logic        ver;
        logic [63:0] ahi;
        logic [63:0] alo;
        logic [63:0] chi;
        logic [63:0] clo;
    } peer_key_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    // operation[1:0], addr_version[2], addr_hi[66:3], addr_lo[130:67],
    // collector_hi[194:131], collector_lo[258:195], asn[290:259], query_id[306:291]
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    // status[1:0], peer_id[17:2], out_version[18], out_addr_hi[82:19],
    // out_addr_lo[146:83], out_collector_hi[210:147], out_collector_lo[274:211],
    // out_asn[306:275], entry_total[315:307]
    logic [OUT_W-1:0]  m_tdata;

    int errors;
    int pending;
    int n_inserted;
    int n_found;
    int n_absent;
    int n_full;

    int        cycle_cnt = 0;
    int        hold_cnt  = 0;
    bit        no_idle   = 1'b0;
    int        words_sent;
    int        ids_issued;
    peer_key_t key_pool [$];

    peer_key_id_interning_table uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    pkit_checker table_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .errors     (errors),
        .pending    (pending),
        .n_inserted (n_inserted),
        .n_found    (n_found),
        .n_absent   (n_absent),
        .n_full     (n_full)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("Run did not finish within %0d cycles.", CYCLE_LIMIT);
            $display("peer_key_id_interning_table: mismatch");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_cnt != 0)
        begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end
        else if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            hold_cnt <= pick_gap();
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Most keys look like real IPv4 or IPv6 peers; some carry arbitrary bits.
    function automatic peer_key_t rand_key();
        peer_key_t k;
        k.ver = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 3) == 0)
        begin
            k.ahi = rand64();
            k.alo = rand64();
        end
        else if (k.ver == 1'b0)
        begin
            k.ahi = '0;
            k.alo = {32'h0, $urandom};
        end
        else
        begin
            k.ahi = rand64();
            k.alo = rand64();
        end
        k.chi = rand64();
        k.clo = ($urandom_range(0, 1) == 0) ? 64'h0 : rand64();
        return k;
    endfunction

    function automatic logic [IN_W-1:0] pack_req(input op_t op, input peer_key_t k,
                                                 input logic [31:0] asn,
                                                 input logic [ID_W-1:0] qid);
        return {{(IN_W-REQ_BITS){1'b0}}, qid, asn, k.clo, k.chi, k.alo, k.ahi, k.ver, op};
    endfunction

    task automatic push_word(input logic [IN_W-1:0] w);
        int gap;
        s_tdata  <= w;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
        gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic intern(input peer_key_t k, input logic [31:0] asn);
        ids_issued++;
        push_word(pack_req(OP_GET_ID, k, asn, ID_W'($urandom_range(0, 65535))));
    endtask

    // The key fields are noise here; the block must ignore them.
    task automatic ask_sig(input logic [ID_W-1:0] qid);
        push_word(pack_req(OP_GET_SIG, rand_key(), $urandom, qid));
    endtask

    task automatic ask_plain(input op_t op);
        push_word(pack_req(op, rand_key(), $urandom, ID_W'($urandom_range(0, 65535))));
    endtask

    function automatic logic [ID_W-1:0] pick_query();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else if (r < 5)
            return ID_W'($urandom_range(0, 65535));
        return ID_W'($urandom_range(1, ids_issued + 1));
    endfunction

    initial
    begin
        peer_key_t k;
        peer_key_t key_a;
        peer_key_t ones_key;
        peer_key_t zero_key;
        int r;

        rst_n      <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        words_sent = 0;
        ids_issued = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty table, matching rules, ID extremes and clear.
        key_a    = '{ver: 1'b0, ahi: 64'h0, alo: 64'h0000_0000_0A00_0001,
                     chi: 64'h636F_6C6C_2D61_0000, clo: 64'h0};
        ones_key = '1;
        zero_key = '0;
        ask_plain(OP_GET_SIZE);
        ask_sig('0);
        ask_sig('1);
        ask_sig(16'd1);
        intern(key_a, 32'd64512);
        intern(key_a, 32'hFFFF_FFFF);
        k = key_a;
        k.ahi = 64'h1;
        intern(k, 32'd1);
        k = key_a;
        k.ver = 1'b1;
        intern(k, 32'd2);
        intern(ones_key, 32'hFFFF_FFFF);
        intern(zero_key, 32'h0);
        intern(zero_key, 32'h1234_5678);
        ask_sig(16'd1);
        ask_sig(16'd5);
        ask_sig(16'd6);
        ask_plain(OP_GET_SIZE);
        ask_plain(OP_CLEAR);
        ask_plain(OP_GET_SIZE);
        ask_sig(16'd1);
        intern(key_a, 32'd7);
        ask_sig(16'd6);
        key_pool.push_back(key_a);
        key_pool.push_back(ones_key);
        key_pool.push_back(zero_key);

        // Fill every slot, then knock on a full table with new and known keys.
        no_idle = 1'b1;
        ask_plain(OP_CLEAR);
        for (int i = 0; i < ENTRIES + 3; i++)
        begin
            if (i == ENTRIES / 2)
                no_idle = 1'b0;
            k = rand_key();
            if (i < 8)
                key_pool.push_back(k);
            intern(k, $urandom);
        end
        intern(key_pool[key_pool.size() - 1], $urandom);
        intern(key_pool[3], $urandom);
        ask_sig(ID_W'($urandom_range(1, ids_issued + 1)));
        ask_sig(pick_query());
        ask_plain(OP_GET_SIZE);
        ask_plain(OP_CLEAR);

        // Random part: mostly lookups and inserts over a pool of recent keys.
        for (int n = 0; n < 1000; n++)
        begin
            if (n % 64 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 30)
            begin
                k = rand_key();
                key_pool.push_back(k);
                if (key_pool.size() > POOL_DEPTH)
                    void'(key_pool.pop_front());
                intern(k, $urandom);
            end
            else if (r < 50)
            begin
                intern(key_pool[$urandom_range(0, key_pool.size() - 1)], $urandom);
            end
            else if (r < 56)
            begin
                // A known key with one bit changed must not match it.
                k = key_pool[$urandom_range(0, key_pool.size() - 1)];
                case ($urandom_range(0, 4))
                    0: k.ver = ~k.ver;
                    1: k.ahi = k.ahi ^ (64'h1 << $urandom_range(0, 63));
                    2: k.alo = k.alo ^ (64'h1 << $urandom_range(0, 63));
                    3: k.chi = k.chi ^ (64'h1 << $urandom_range(0, 63));
                    default: k.clo = k.clo ^ (64'h1 << $urandom_range(0, 63));
                endcase
                intern(k, $urandom);
            end
            else if (r < 80)
            begin
                ask_sig(pick_query());
            end
            else if (r < 93)
            begin
                ask_plain(OP_GET_SIZE);
            end
            else if (r < 96)
            begin
                ask_plain(OP_CLEAR);
            end
            else
            begin
                k = '{ver: 1'($urandom_range(0, 1)), ahi: rand64(), alo: rand64(),
                       chi: rand64(), clo: rand64()};
                intern(k, $urandom);
            end
        end

        no_idle = 1'b0;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d request words over %0d cycles, including a completely full table.",
                 words_sent, cycle_cnt);
        $display("Results: %0d inserted, %0d found, %0d not found, %0d refused as full.",
                 n_inserted, n_found, n_absent, n_full);
        if (pending != 0)
            $display("%0d result words never arrived.", pending);
        if (errors == 0 && pending == 0)
            $display("peer_key_id_interning_table: match");
        else
            $display("peer_key_id_interning_table: mismatch");
        $finish;
    end

endmodule

// File: sim.f
sv/pkit_pkg.sv
sv/pkit_store.sv
sv/peer_key_id_interning_table.sv
tb/pkit_checker.sv
tb/tb_peer_key_id_interning_table.sv
